/* rtl/jsu_pkg.sv */
// Package for the JSON string unescape block: item types, state types,
// result codes and small lookup functions. It depends on nothing else.
package jsu_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [2:0] error_code;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  hex_count;
		logic [15:0] code_accum;
		logic        hex_bad_seen;
	} state_t;

	localparam int unsigned MaxResults = 3;

	typedef struct packed {
		logic [1:0]                     cnt;
		out_item_t [MaxResults-1:0]     res;
	} group_t;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
	localparam logic [2:0] ERR_UNTERM_STR = 3'd2;
	localparam logic [2:0] ERR_UNTERM_ESC = 3'd3;
	localparam logic [2:0] ERR_SHORT_HEX  = 3'd4;
	localparam logic [2:0] ERR_BAD_HEX    = 3'd5;
	localparam logic [2:0] ERR_BAD_ESC    = 3'd6;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;

	function automatic out_item_t mk_item(logic [7:0] b, logic [1:0] k, logic [2:0] e);
		out_item_t it;
		it.out_byte   = b;
		it.kind       = k;
		it.error_code = e;
		it.last       = 1'b0;
		return it;
	endfunction

	// Returns {ok, value}.
	function automatic logic [4:0] hex_value(logic [7:0] h);
		logic [4:0] r;
		r = 5'd0;
		if (h >= 8'h30 && h <= 8'h39) begin
			r = {1'b1, h[3:0]};
		end else if ((h >= 8'h61 && h <= 8'h66) || (h >= 8'h41 && h <= 8'h46)) begin
			r = {1'b1, h[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Returns {ok, byte}.
	function automatic logic [8:0] escape_byte(logic [7:0] e);
		logic [8:0] r;
		unique case (e)
			8'h22:   r = {1'b1, 8'h22};
			8'h5C:   r = {1'b1, 8'h5C};
			8'h2F:   r = {1'b1, 8'h2F};
			8'h62:   r = {1'b1, 8'h08};
			8'h66:   r = {1'b1, 8'h0C};
			8'h6E:   r = {1'b1, 8'h0A};
			8'h72:   r = {1'b1, 8'h0D};
			8'h74:   r = {1'b1, 8'h09};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/json_string_unescape.sv */
// Top level of the JSON string unescape block: input register, parser state,
// and the result buffer that hands out one result per cycle while res_stall is low.
// Depends on jsu_pkg and jsu_decode.
//
// Usage: the byte channel (byte_valid, byte_stall, byte_item) carries one text
// byte or an end-of-text event per item. The result channel (res_valid,
// res_stall, res_item) carries decoded bytes, a done result at the closing
// quote, or an error result; last marks the final result of each input item.
// An item is accepted at an edge where valid is high and stall is low.
// An item is registered in the input register on acceptance, then decoded
// into the result buffer once that buffer is free, and its first result
// shows from there. Throughput is one item per cycle while each item gives
// at most one result and the receiver does not stall; a hex escape ending in
// a two- or three-byte UTF-8 sequence holds the byte channel until its group
// drains, because the result port moves one result per cycle. When the receiver
// stalls, the buffer holds its results, the input register fills, and byte_stall
// rises until results move again. Reset clears the parser to idle, awaiting an
// opening quote, and empties the input register and the result buffer.
module json_string_unescape (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  jsu_pkg::in_item_t   byte_item,
	output logic                res_valid,
	input  logic                res_stall,
	output jsu_pkg::out_item_t  res_item
);

	jsu_pkg::in_item_t  item_s1;
	logic               vld_s1;
	jsu_pkg::state_t    st_q;
	jsu_pkg::state_t    st_next;
	jsu_pkg::group_t    grp;
	jsu_pkg::out_item_t res_q [jsu_pkg::MaxResults];
	logic [1:0]         cnt_q;
	logic               pop;
	logic               grp_free;
	logic               advance;
	logic               accept;

	jsu_decode u_decode (
		.item (item_s1),
		.cur  (st_q),
		.nxt  (st_next),
		.grp  (grp)
	);

	assign res_valid  = (cnt_q != 2'd0);
	assign res_item   = res_q[0];
	assign pop        = res_valid && !res_stall;
	assign grp_free   = (cnt_q == 2'd0) || (pop && cnt_q == 2'd1);
	assign advance    = vld_s1 && grp_free;
	assign byte_stall = vld_s1 && !grp_free;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			st_q   <= '{phase: jsu_pkg::PH_IDLE, hex_count: 2'd0,
				code_accum: 16'd0, hex_bad_seen: 1'b0};
			cnt_q  <= 2'd0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				st_q  <= st_next;
				cnt_q <= grp.cnt;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_item;
		end
		if (advance) begin
			res_q[0] <= grp.res[0];
			res_q[1] <= grp.res[1];
			res_q[2] <= grp.res[2];
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && cnt_q == 2'd1) |-> res_item.last)
		else $error("Final buffered result lacks last.");

	a_not_last_early: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q > 2'd1) |-> !res_item.last)
		else $error("Last set before the group is drained.");

	a_nonbyte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.kind != jsu_pkg::KIND_BYTE) |->
		(res_item.out_byte == 8'd0 && res_item.last))
		else $error("Done or error result carries a byte or is not last.");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q > 2'd1) |=> res_valid)
		else $error("Result group dropped before it was drained.");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> vld_s1)
		else $error("Byte channel stalled with an empty input register.");

endmodule

/* rtl/jsu_decode.sv */
// Decoder for one text item: next parser state and the group of up to three
// results that the item causes. Depends on jsu_pkg.
module jsu_decode (
	input  jsu_pkg::in_item_t item,
	input  jsu_pkg::state_t   cur,
	output jsu_pkg::state_t   nxt,
	output jsu_pkg::group_t   grp
);

	logic [7:0]  b;
	logic        eot;
	logic [4:0]  hv;
	logic [8:0]  ev;
	logic [15:0] code_next;
	logic [15:0] cp;
	logic        bad_next;

	assign b         = item.data_byte;
	assign eot       = item.end_of_text;
	assign hv        = jsu_pkg::hex_value(b);
	assign ev        = jsu_pkg::escape_byte(b);
	assign code_next = {cur.code_accum[11:0], hv[4] ? hv[3:0] : 4'd0};
	assign bad_next  = cur.hex_bad_seen | ~hv[4];
	assign cp        = (code_next[15:11] == 5'b11011) ? jsu_pkg::REPLACEMENT_CHAR : code_next;

	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			jsu_pkg::PH_IDLE: begin
				if (!eot && b == jsu_pkg::CH_QUOTE) begin
					nxt.phase = jsu_pkg::PH_BODY;
				end
			end
			jsu_pkg::PH_BODY: begin
				if (eot || b == jsu_pkg::CH_QUOTE) begin
					nxt.phase = jsu_pkg::PH_IDLE;
				end else if (b == jsu_pkg::CH_BSLASH) begin
					nxt.phase = jsu_pkg::PH_ESC;
				end
			end
			jsu_pkg::PH_ESC: begin
				if (eot) begin
					nxt.phase = jsu_pkg::PH_IDLE;
				end else if (b == jsu_pkg::CH_U) begin
					nxt.phase        = jsu_pkg::PH_HEX;
					nxt.hex_count    = 2'd0;
					nxt.code_accum   = 16'd0;
					nxt.hex_bad_seen = 1'b0;
				end else if (ev[8]) begin
					nxt.phase = jsu_pkg::PH_BODY;
				end else begin
					nxt.phase = jsu_pkg::PH_IDLE;
				end
			end
			jsu_pkg::PH_HEX: begin
				if (eot) begin
					nxt.phase = jsu_pkg::PH_IDLE;
				end else begin
					nxt.code_accum   = code_next;
					nxt.hex_bad_seen = bad_next;
					nxt.hex_count    = cur.hex_count + 2'd1;
					if (cur.hex_count == 2'd3) begin
						nxt.phase = bad_next ? jsu_pkg::PH_IDLE : jsu_pkg::PH_BODY;
					end
				end
			end
			default: nxt = cur;
		endcase
	end

	always_comb begin
		grp = '0;
		unique case (cur.phase)
			jsu_pkg::PH_IDLE: begin
				if (eot || b != jsu_pkg::CH_QUOTE) begin
					grp.cnt    = 2'd1;
					grp.res[0] = jsu_pkg::mk_item(8'd0, jsu_pkg::KIND_ERR,
						jsu_pkg::ERR_NO_QUOTE);
				end
			end
			jsu_pkg::PH_BODY: begin
				if (eot) begin
					grp.cnt    = 2'd1;
					grp.res[0] = jsu_pkg::mk_item(8'd0, jsu_pkg::KIND_ERR,
						jsu_pkg::ERR_UNTERM_STR);
				end else if (b == jsu_pkg::CH_QUOTE) begin
					grp.cnt    = 2'd1;
					grp.res[0] = jsu_pkg::mk_item(8'd0, jsu_pkg::KIND_DONE,
						jsu_pkg::ERR_NONE);
				end else if (b != jsu_pkg::CH_BSLASH) begin
					grp.cnt    = 2'd1;
					grp.res[0] = jsu_pkg::mk_item(b, jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
				end
			end
			jsu_pkg::PH_ESC: begin
				if (eot) begin
					grp.cnt    = 2'd1;
					grp.res[0] = jsu_pkg::mk_item(8'd0, jsu_pkg::KIND_ERR,
						jsu_pkg::ERR_UNTERM_ESC);
				end else if (b != jsu_pkg::CH_U) begin
					grp.cnt = 2'd1;
					if (ev[8]) begin
						grp.res[0] = jsu_pkg::mk_item(ev[7:0], jsu_pkg::KIND_BYTE,
							jsu_pkg::ERR_NONE);
					end else begin
						grp.res[0] = jsu_pkg::mk_item(8'd0, jsu_pkg::KIND_ERR,
							jsu_pkg::ERR_BAD_ESC);
					end
				end
			end
			jsu_pkg::PH_HEX: begin
				if (eot) begin
					grp.cnt    = 2'd1;
					grp.res[0] = jsu_pkg::mk_item(8'd0, jsu_pkg::KIND_ERR,
						jsu_pkg::ERR_SHORT_HEX);
				end else if (cur.hex_count == 2'd3) begin
					if (bad_next) begin
						grp.cnt    = 2'd1;
						grp.res[0] = jsu_pkg::mk_item(8'd0, jsu_pkg::KIND_ERR,
							jsu_pkg::ERR_BAD_HEX);
					end else if (cp < 16'h0080) begin
						grp.cnt    = 2'd1;
						grp.res[0] = jsu_pkg::mk_item(cp[7:0], jsu_pkg::KIND_BYTE,
							jsu_pkg::ERR_NONE);
					end else if (cp < 16'h0800) begin
						grp.cnt    = 2'd2;
						grp.res[0] = jsu_pkg::mk_item({3'b110, cp[10:6]},
							jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
						grp.res[1] = jsu_pkg::mk_item({2'b10, cp[5:0]},
							jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
					end else begin
						grp.cnt    = 2'd3;
						grp.res[0] = jsu_pkg::mk_item({4'b1110, cp[15:12]},
							jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
						grp.res[1] = jsu_pkg::mk_item({2'b10, cp[11:6]},
							jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
						grp.res[2] = jsu_pkg::mk_item({2'b10, cp[5:0]},
							jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
					end
				end
			end
			default: grp = '0;
		endcase
		if (grp.cnt != 2'd0) begin
			grp.res[grp.cnt - 2'd1].last = 1'b1;
		end
	end

endmodule
